@@ design/balu_pkg.sv @@
package balu_pkg;

   typedef enum logic [4:0] {
      OP_AND = 5'd0,
      OP_ORA = 5'd1,
      OP_EOR = 5'd2,
      OP_ROR = 5'd3,
      OP_ROL = 5'd4,
      OP_ASL = 5'd5,
      OP_LSR = 5'd6,
      OP_BIT = 5'd7,
      OP_CMP = 5'd8,
      OP_CPX = 5'd9,
      OP_CPY = 5'd10,
      OP_DEC = 5'd11,
      OP_INC = 5'd12,
      OP_LOAD = 5'd13,
      OP_ADC = 5'd14,
      OP_SBC = 5'd15,
      OP_SBX = 5'd16,
      OP_ARR = 5'd17,
      OP_LAS = 5'd18,
      OP_ANE = 5'd19,
      OP_LAX = 5'd20
   } alu_op_type;

   localparam int OpWidth = 5;
   localparam int DataWidth = 8;
   localparam int MaskWidth = 4;

   localparam logic [DataWidth-1:0] MAGIC_RESET = 8'hEE;

   localparam logic [MaskWidth-1:0] MASK_NONE = 4'b0000;
   localparam logic [MaskWidth-1:0] MASK_ZN = 4'b0110;
   localparam logic [MaskWidth-1:0] MASK_CZN = 4'b0111;
   localparam logic [MaskWidth-1:0] MASK_ZNV = 4'b1110;
   localparam logic [MaskWidth-1:0] MASK_ALL = 4'b1111;

   localparam logic [3:0] BCD_NIBBLE_ADJ = 4'h6;
   localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
   localparam logic [7:0] BCD_HIGH_ADJ = 8'h60;
   localparam logic [7:0] BCD_BYTE_LIMIT = 8'h9F;
   localparam logic [3:0] ARR_DIGIT_LIMIT = 4'h5;

endpackage

@@ design/balu_req_if.sv @@
interface balu_req_if;
   import balu_pkg::*;

   logic valid;
   logic ready;
   logic [OpWidth-1:0] req_type;
   logic [DataWidth-1:0] accumulator;
   logic [DataWidth-1:0] index_x;
   logic [DataWidth-1:0] index_y;
   logic [DataWidth-1:0] stack_ptr;
   logic [DataWidth-1:0] operand;
   logic carry_in;
   logic decimal_mode;

   modport source (
      output valid, req_type, accumulator, index_x, index_y, stack_ptr, operand,
             carry_in, decimal_mode,
      input ready
   );

   modport sink (
      input valid, req_type, accumulator, index_x, index_y, stack_ptr, operand,
            carry_in, decimal_mode,
      output ready
   );

endinterface

@@ design/balu_rsp_if.sv @@
interface balu_rsp_if;
   import balu_pkg::*;

   logic valid;
   logic ready;
   logic [DataWidth-1:0] result;
   logic carry_out;
   logic zero_out;
   logic negative_out;
   logic overflow_out;
   logic [MaskWidth-1:0] flag_mask;
   logic so_block;

   modport source (
      output valid, result, carry_out, zero_out, negative_out, overflow_out,
             flag_mask, so_block,
      input ready
   );

   modport sink (
      input valid, result, carry_out, zero_out, negative_out, overflow_out,
            flag_mask, so_block,
      output ready
   );

endinterface

@@ design/bcd_capable_8bit_cpu_alu.sv @@
// Channel    Direction  Contents
// req_chan   in         operation, A, X, Y, S, operand, carry, decimal flag
// rsp_chan   out        result byte, C/Z/N/V, flag mask, set-overflow block
// csr_*      in         write enable and data of the magic constant
//
// Each transaction passes the input register, then the ALU logic, then the result register.
// One transaction per cycle is sustained while rsp_chan.ready is high.
// Reset is synchronous and active high; the magic constant returns to 0xEE.
// A stalled result holds in its register while the input register still takes
// one more transaction; ready drops only when both registers are full.
module bcd_capable_8bit_cpu_alu (
   input logic clock,
   input logic reset,
   balu_req_if.sink req_chan,
   balu_rsp_if.source rsp_chan,
   input logic csr_write_enable,
   input logic [balu_pkg::DataWidth-1:0] csr_write_data
);
   import balu_pkg::*;

   logic [DataWidth-1:0] magic_ff;

   logic s1_valid_ff;
   logic [OpWidth-1:0] s1_op_ff;
   logic [DataWidth-1:0] s1_a_ff;
   logic [DataWidth-1:0] s1_x_ff;
   logic [DataWidth-1:0] s1_y_ff;
   logic [DataWidth-1:0] s1_s_ff;
   logic [DataWidth-1:0] s1_d_ff;
   logic s1_c_ff;
   logic s1_dm_ff;

   logic out_valid_ff;
   logic [DataWidth-1:0] out_result_ff;
   logic out_c_ff;
   logic out_z_ff;
   logic out_n_ff;
   logic out_v_ff;
   logic [MaskWidth-1:0] out_mask_ff;
   logic out_so_ff;

   logic out_free;
   logic s1_advance;
   logic req_take;

   logic [DataWidth-1:0] res_in;
   logic c_in;
   logic z_in;
   logic n_in;
   logic v_in;
   logic [MaskWidth-1:0] mask_in;
   logic so_in;

   logic [DataWidth-1:0] cmp_src;
   logic [8:0] cmp_diff;
   logic [8:0] adc_bin;
   logic [5:0] adc_lo;
   logic [5:0] adc_lo_adj;
   logic adc_hc;
   logic [9:0] adc_dec;
   logic [9:0] adc_t;
   logic [9:0] adc_fix;
   logic [8:0] sbc_bin;
   logic [5:0] sbc_lo;
   logic [5:0] sbc_lo_dif;
   logic [5:0] sbc_lo_fix;
   logic [9:0] sbc_hi;
   logic [9:0] sbc_hi_fix;
   logic [7:0] arr_t;
   logic [7:0] arr_r0;
   logic [7:0] arr_r1;
   logic [4:0] arr_lo_sum;
   logic [4:0] arr_hi_sum;
   logic arr_hc;
   logic [7:0] arr_r2;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || out_free;
   assign req_take = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
      end else if (csr_write_enable) begin
         magic_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff <= req_chan.req_type;
         s1_a_ff <= req_chan.accumulator;
         s1_x_ff <= req_chan.index_x;
         s1_y_ff <= req_chan.index_y;
         s1_s_ff <= req_chan.stack_ptr;
         s1_d_ff <= req_chan.operand;
         s1_c_ff <= req_chan.carry_in;
         s1_dm_ff <= req_chan.decimal_mode;
      end
   end

   always_comb begin
      cmp_src = s1_a_ff;
      case (s1_op_ff)
         OP_CPX: cmp_src = s1_x_ff;
         OP_CPY: cmp_src = s1_y_ff;
         OP_SBX: cmp_src = s1_a_ff & s1_x_ff;
         default: cmp_src = s1_a_ff;
      endcase
      cmp_diff = {1'b0, cmp_src} - {1'b0, s1_d_ff};

      adc_bin = {1'b0, s1_a_ff} + {1'b0, s1_d_ff} + {8'd0, s1_c_ff};
      adc_lo = {2'b00, s1_a_ff[3:0]} + {2'b00, s1_d_ff[3:0]} + {5'd0, s1_c_ff};
      adc_lo_adj = (adc_lo > {2'b00, BCD_DIGIT_MAX}) ?
                   adc_lo + {2'b00, BCD_NIBBLE_ADJ} : adc_lo;
      adc_hc = adc_lo_adj > 6'd15;
      adc_dec = {2'b00, s1_a_ff[7:4], 4'h0} + {2'b00, s1_d_ff[7:4], 4'h0}
              + {5'd0, adc_hc, 4'h0} + {6'd0, adc_lo_adj[3:0]};
      adc_t = s1_dm_ff ? adc_dec : {1'b0, adc_bin};
      adc_fix = (s1_dm_ff && adc_t > {2'b00, BCD_BYTE_LIMIT}) ?
                adc_t + {2'b00, BCD_HIGH_ADJ} : adc_t;

      sbc_bin = {1'b0, s1_a_ff} + {1'b0, ~s1_d_ff} + {8'd0, s1_c_ff};
      sbc_lo = {2'b00, s1_a_ff[3:0]} - {2'b00, s1_d_ff[3:0]} - {5'd0, !s1_c_ff};
      sbc_lo_dif = sbc_lo - {2'b00, BCD_NIBBLE_ADJ};
      sbc_lo_fix = sbc_lo[5] ? {2'b11, sbc_lo_dif[3:0]} : sbc_lo;
      sbc_hi = {2'b00, s1_a_ff[7:4], 4'h0} - {2'b00, s1_d_ff[7:4], 4'h0}
             + {{4{sbc_lo_fix[5]}}, sbc_lo_fix};
      sbc_hi_fix = sbc_hi[9] ? sbc_hi - {2'b00, BCD_HIGH_ADJ} : sbc_hi;

      arr_t = s1_a_ff & s1_d_ff;
      arr_r0 = {s1_c_ff, arr_t[7:1]};
      arr_lo_sum = {1'b0, arr_t[3:0]} + {4'd0, arr_t[0]};
      arr_hi_sum = {1'b0, arr_t[7:4]} + {4'd0, arr_t[4]};
      arr_r1 = (arr_lo_sum > {1'b0, ARR_DIGIT_LIMIT}) ?
               {arr_r0[7:4], arr_r0[3:0] + BCD_NIBBLE_ADJ} : arr_r0;
      arr_hc = arr_hi_sum > {1'b0, ARR_DIGIT_LIMIT};
      arr_r2 = arr_hc ? arr_r1 + BCD_HIGH_ADJ : arr_r1;

      res_in = '0;
      c_in = 1'b0;
      z_in = 1'b0;
      n_in = 1'b0;
      v_in = 1'b0;
      mask_in = MASK_NONE;
      so_in = 1'b0;

      unique case (s1_op_ff)
         OP_AND: begin
            res_in = s1_a_ff & s1_d_ff;
            mask_in = MASK_ZN;
         end
         OP_ORA: begin
            res_in = s1_a_ff | s1_d_ff;
            mask_in = MASK_ZN;
         end
         OP_EOR: begin
            res_in = s1_a_ff ^ s1_d_ff;
            mask_in = MASK_ZN;
         end
         OP_ROR: begin
            res_in = {s1_c_ff, s1_d_ff[7:1]};
            c_in = s1_d_ff[0];
            mask_in = MASK_CZN;
         end
         OP_ROL: begin
            res_in = {s1_d_ff[6:0], s1_c_ff};
            c_in = s1_d_ff[7];
            mask_in = MASK_CZN;
         end
         OP_ASL: begin
            res_in = {s1_d_ff[6:0], 1'b0};
            c_in = s1_d_ff[7];
            mask_in = MASK_CZN;
         end
         OP_LSR: begin
            res_in = {1'b0, s1_d_ff[7:1]};
            c_in = s1_d_ff[0];
            mask_in = MASK_CZN;
         end
         OP_BIT: begin
            res_in = s1_a_ff;
            mask_in = MASK_ZNV;
            so_in = 1'b1;
         end
         OP_CMP, OP_CPX, OP_CPY: begin
            res_in = cmp_src;
            mask_in = MASK_CZN;
         end
         OP_SBX: begin
            res_in = cmp_diff[7:0];
            mask_in = MASK_CZN;
         end
         OP_DEC: begin
            res_in = s1_d_ff - 8'd1;
            mask_in = MASK_ZN;
         end
         OP_INC: begin
            res_in = s1_d_ff + 8'd1;
            mask_in = MASK_ZN;
         end
         OP_LOAD: begin
            res_in = s1_d_ff;
            mask_in = MASK_ZN;
         end
         OP_ADC: begin
            res_in = adc_fix[7:0];
            mask_in = MASK_ALL;
            so_in = 1'b1;
         end
         OP_SBC: begin
            res_in = s1_dm_ff ? sbc_hi_fix[7:0] : sbc_bin[7:0];
            mask_in = MASK_ALL;
            so_in = 1'b1;
         end
         OP_ARR: begin
            res_in = s1_dm_ff ? arr_r2 : arr_r0;
            mask_in = MASK_ALL;
            so_in = !s1_dm_ff;
         end
         OP_LAS: begin
            res_in = s1_d_ff & s1_s_ff;
            mask_in = MASK_ZN;
         end
         OP_ANE: begin
            res_in = (s1_a_ff | magic_ff) & s1_x_ff & s1_d_ff;
            mask_in = MASK_ZN;
         end
         OP_LAX: begin
            res_in = (s1_a_ff | magic_ff) & s1_d_ff;
            mask_in = MASK_ZN;
         end
         default: begin
            res_in = '0;
            mask_in = MASK_NONE;
         end
      endcase

      case (s1_op_ff)
         OP_BIT: begin
            z_in = (s1_a_ff & s1_d_ff) == 8'h00;
            n_in = s1_d_ff[7];
            v_in = s1_d_ff[6];
         end
         OP_CMP, OP_CPX, OP_CPY, OP_SBX: begin
            c_in = !cmp_diff[8];
            z_in = cmp_diff[7:0] == 8'h00;
            n_in = cmp_diff[7];
         end
         OP_ADC: begin
            c_in = |adc_fix[9:8];
            z_in = adc_bin[7:0] == 8'h00;
            n_in = adc_t[7];
            v_in = !(s1_a_ff[7] ^ s1_d_ff[7]) && (s1_a_ff[7] ^ adc_t[7]);
         end
         OP_SBC: begin
            c_in = sbc_bin[8];
            z_in = sbc_bin[7:0] == 8'h00;
            n_in = sbc_bin[7];
            v_in = (s1_a_ff[7] ^ s1_d_ff[7]) && (s1_a_ff[7] ^ sbc_bin[7]);
         end
         OP_ARR: begin
            if (s1_dm_ff) begin
               c_in = arr_hc;
               z_in = arr_r0 == 8'h00;
               n_in = s1_c_ff;
               v_in = arr_t[6] ^ arr_r0[6];
            end else begin
               c_in = arr_t[7];
               z_in = arr_r0 == 8'h00;
               n_in = arr_r0[7];
               v_in = arr_t[7] ^ arr_t[6];
            end
         end
         default: begin
            if (mask_in != MASK_NONE) begin
               z_in = res_in == 8'h00;
               n_in = res_in[7];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_result_ff <= res_in;
         out_c_ff <= c_in;
         out_z_ff <= z_in;
         out_n_ff <= n_in;
         out_v_ff <= v_in;
         out_mask_ff <= mask_in;
         out_so_ff <= so_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.result = out_result_ff;
   assign rsp_chan.carry_out = out_c_ff;
   assign rsp_chan.zero_out = out_z_ff;
   assign rsp_chan.negative_out = out_n_ff;
   assign rsp_chan.overflow_out = out_v_ff;
   assign rsp_chan.flag_mask = out_mask_ff;
   assign rsp_chan.so_block = out_so_ff;

`ifndef SYNTHESIS
   a_magic_reset: assert property (@(posedge clock)
      $past(reset) && !$past(csr_write_enable) |-> magic_ff == MAGIC_RESET)
      else $error("magic constant not restored by reset");

   a_unwritten_flags_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_c_ff & !out_mask_ff[0]) | (out_z_ff & !out_mask_ff[1])
         | (out_n_ff & !out_mask_ff[2]) | (out_v_ff & !out_mask_ff[3])) == 1'b0)
      else $error("flag set outside its mask");

   a_so_needs_overflow: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_so_ff |-> out_mask_ff[3] && out_mask_ff[1])
      else $error("set-overflow block without overflow write");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> out_valid_ff)
      else $error("transaction lost between stages");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff)
      else $error("stalled transaction dropped from input register");
`endif

endmodule
